// ===== hw/rtl/tpfm_pkg.sv =====
// Package for the tone period frequency meter.
// Item types, configuration types, register indexes and sequencer states.
// No dependencies.
package tpfm_pkg;

  localparam int unsigned TimeWidth = 48;
  localparam int unsigned FreqWidth = 32;
  localparam int unsigned CntWidth  = 32;
  localparam int unsigned CfgWidth  = 48;
  localparam int unsigned IdxWidth  = 2;
  localparam int unsigned DivSteps  = FreqWidth;
  localparam int unsigned StepWidth = $clog2(DivSteps);

  localparam logic [FreqWidth-1:0] ClockHzReset = FreqWidth'(16000000);
  localparam logic [TimeWidth-1:0] TimeoutReset = TimeWidth'(800000);
  localparam logic [TimeWidth-1:0] IntervalReset = TimeWidth'(320000);

  typedef enum logic [IdxWidth-1:0] {
    REG_CLOCK_HZ        = 2'd0,
    REG_SILENCE_TIMEOUT = 2'd1,
    REG_CHECK_INTERVAL  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_TOGGLE = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 operation;
    logic [TimeWidth-1:0] now_cycle;
  } in_item_t;

  typedef struct packed {
    logic [FreqWidth-1:0] tone_hz;
    logic                 tone_active;
    logic [CntWidth-1:0]  toggles_seen;
    logic [TimeWidth-1:0] next_check_cycle;
  } out_item_t;

  typedef struct packed {
    logic [FreqWidth-1:0] clock_hz;
    logic [TimeWidth-1:0] silence_timeout;
    logic [TimeWidth-1:0] check_interval;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [FreqWidth-1:0] dividend;
    logic [FreqWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FreqWidth-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/tpfm_cfg.sv =====
// Configuration register file of the tone period frequency meter.
// Depends on tpfm_pkg.
module tpfm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpfm_pkg::IdxWidth-1:0] cfg_index_i,
  input  logic [tpfm_pkg::CfgWidth-1:0] cfg_wdata_i,
  output tpfm_pkg::cfg_t                cfg_o
);

  tpfm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tpfm_pkg::reg_idx_e'(cfg_index_i))
        tpfm_pkg::REG_CLOCK_HZ:
          cfg_d.clock_hz = cfg_wdata_i[tpfm_pkg::FreqWidth-1:0];
        tpfm_pkg::REG_SILENCE_TIMEOUT:
          cfg_d.silence_timeout = cfg_wdata_i[tpfm_pkg::TimeWidth-1:0];
        tpfm_pkg::REG_CHECK_INTERVAL:
          cfg_d.check_interval = cfg_wdata_i[tpfm_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_hz        <= tpfm_pkg::ClockHzReset;
      cfg_q.silence_timeout <= tpfm_pkg::TimeoutReset;
      cfg_q.check_interval  <= tpfm_pkg::IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/tpfm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tpfm_pkg.
module tpfm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpfm_pkg::div_req_t req_i,
  output tpfm_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = tpfm_pkg::FreqWidth;

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [tpfm_pkg::StepWidth-1:0]    cnt_q, cnt_d;
  logic [W-1:0]                      rem_q, rem_d;
  logic [W-1:0]                      quo_q, quo_d;
  logic [W-1:0]                      dvs_q, dvs_d;
  logic [W:0]                        trial;
  logic [W+1:0]                      diff;
  logic                              ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tpfm_pkg::StepWidth'(tpfm_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hw/rtl/tone_period_frequency_meter_unit.sv =====
// Top level of the tone period frequency meter: sequencer, meter state, result register.
// Depends on tpfm_pkg, tpfm_cfg and tpfm_div.

// Each item (pin toggle or silence check) is taken one at a time and gives one
// result. A check, or a toggle that needs no division, passes through the gap,
// evaluate and done states; a toggle that measures a period also waits in the
// divide state for the 32-step divider that forms clock_hz / (2 * gap). The next
// item can be accepted in the same cycle that the result first sits in the output
// register; while the output is stalled, a finished item waits in the done state.
module tone_period_frequency_meter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tpfm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tpfm_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tpfm_pkg::IdxWidth-1:0] cfg_index_i,
  input  logic [tpfm_pkg::CfgWidth-1:0] cfg_wdata_i
);

  localparam int unsigned TW = tpfm_pkg::TimeWidth;
  localparam int unsigned FW = tpfm_pkg::FreqWidth;

  tpfm_pkg::state_e   state_q, state_d;
  tpfm_pkg::cfg_t     cfg;
  tpfm_pkg::div_req_t div_req;
  tpfm_pkg::div_rsp_t div_rsp;

  logic                        div_start;
  logic                        op_q, op_d;
  logic [TW-1:0]               now_q, now_d;
  logic [TW-1:0]               gap_q, gap_d;
  logic [TW-1:0]               next_q, next_d;
  logic [TW-1:0]               last_q, last_d;
  logic [FW-1:0]               freq_q, freq_d;
  logic                        active_q, active_d;
  logic [tpfm_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                        seen_q, seen_d;
  logic                        out_valid_q, out_valid_d;
  tpfm_pkg::out_item_t         out_q, out_d;

  tpfm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  tpfm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_ready_o = (state_q == tpfm_pkg::ST_IDLE);
  assign div_req    = '{start:    div_start,
                        dividend: {1'b0, cfg.clock_hz[FW-1:1]},
                        divisor:  gap_q[FW-1:0]};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    now_d       = now_q;
    gap_d       = gap_q;
    next_d      = next_q;
    last_d      = last_q;
    freq_d      = freq_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tpfm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          now_d   = in_data_i.now_cycle;
          state_d = tpfm_pkg::ST_GAP;
        end
      end
      tpfm_pkg::ST_GAP: begin
        gap_d   = now_q - last_q;
        state_d = tpfm_pkg::ST_EVAL;
      end
      tpfm_pkg::ST_EVAL: begin
        if (tpfm_pkg::op_e'(op_q) == tpfm_pkg::OP_TOGGLE) begin
          next_d  = '0;
          last_d  = now_q;
          seen_d  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = tpfm_pkg::ST_DONE;
          if (seen_q && (gap_q != '0)) begin
            if (gap_q[TW-1:FW] == '0) begin
              div_start = 1'b1;
              state_d   = tpfm_pkg::ST_DIV;
            end else begin
              freq_d   = '0;
              active_d = 1'b1;
            end
          end
        end else begin
          next_d = now_q + cfg.check_interval;
          if (gap_q > cfg.silence_timeout) begin
            freq_d   = '0;
            active_d = 1'b0;
          end
          state_d = tpfm_pkg::ST_DONE;
        end
      end
      tpfm_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          freq_d   = div_rsp.quotient;
          active_d = 1'b1;
          state_d  = tpfm_pkg::ST_DONE;
        end
      end
      tpfm_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.tone_hz          = freq_q;
          out_d.tone_active      = active_q;
          out_d.toggles_seen     = cnt_q;
          out_d.next_check_cycle = next_q;
          out_valid_d            = 1'b1;
          state_d                = tpfm_pkg::ST_IDLE;
        end
      end
      default: state_d = tpfm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpfm_pkg::ST_IDLE;
      last_q      <= '0;
      freq_q      <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      freq_q      <= freq_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    now_q  <= now_d;
    gap_q  <= gap_d;
    next_q <= next_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tpfm_checker.sv =====
// Port-level checker for the tone period frequency meter, bound to the top level.
// Depends on tpfm_pkg and tone_period_frequency_meter_unit.
module tpfm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  tpfm_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  tpfm_pkg::out_item_t           out_data_o
);

  // one item in flight: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a result appears only after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item");

  // a silent tone reports no frequency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tone_active |-> out_data_o.tone_hz == '0)
    else $error("inactive tone with nonzero frequency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // a waiting input item holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("waiting input item dropped or changed");

endmodule

bind tone_period_frequency_meter_unit tpfm_checker u_tpfm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== verif/tb.sv =====
// Testbench for tone_period_frequency_meter_unit: directed corners, back-pressure and
// random tone bursts checked item by item against an in-bench meter model.
// Depends on tpfm_pkg and tone_period_frequency_meter_unit.
module tb;
  import tpfm_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam logic [IdxWidth-1:0] RegSpare = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [IdxWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  // meter model state and registers
  logic [FreqWidth-1:0] m_clock_hz = ClockHzReset;
  logic [TimeWidth-1:0] m_timeout  = TimeoutReset;
  logic [TimeWidth-1:0] m_interval = IntervalReset;
  logic [TimeWidth-1:0] m_last     = '0;
  logic [FreqWidth-1:0] m_freq     = '0;
  logic                 m_active   = 1'b0;
  logic [CntWidth-1:0]  m_count    = '0;
  logic                 m_seen     = 1'b0;

  out_item_t   expected_readings[$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          bursty      = 1'b1;
  int unsigned cycle_count = 0;

  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  logic [5:0]  rx_phase   = '0;

  tone_period_frequency_meter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic out_item_t meter_predict(in_item_t ev);
    out_item_t            r;
    logic [TimeWidth-1:0] gap;
    logic [63:0]          quot;
    gap = ev.now_cycle - m_last;
    r.next_check_cycle = '0;
    if (op_e'(ev.operation) == OP_TOGGLE) begin
      if (m_seen && gap != '0) begin
        quot = 64'd0;
        if (gap[TimeWidth-1:FreqWidth] == '0) quot = 64'(m_clock_hz) / (64'(gap) << 1);
        m_freq   = quot[FreqWidth-1:0];
        m_active = 1'b1;
      end
      m_last  = ev.now_cycle;
      m_seen  = 1'b1;
      m_count = m_count + 1'b1;
    end else begin
      if (gap > m_timeout) begin
        m_active = 1'b0;
        m_freq   = '0;
      end
      r.next_check_cycle = ev.now_cycle + m_interval;
    end
    r.tone_hz      = m_freq;
    r.tone_active  = m_active;
    r.toggles_seen = m_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected item, toggles_seen", 64'(got.toggles_seen), 64'd0);
      end else begin
        want = expected_readings.pop_front();
        if (got.tone_hz !== want.tone_hz)
          report_mismatch("tone_hz", 64'(got.tone_hz), 64'(want.tone_hz));
        if (got.tone_active !== want.tone_active)
          report_mismatch("tone_active", 64'(got.tone_active), 64'(want.tone_active));
        if (got.toggles_seen !== want.toggles_seen)
          report_mismatch("toggles_seen", 64'(got.toggles_seen), 64'(want.toggles_seen));
        if (got.next_check_cycle !== want.next_check_cycle)
          report_mismatch("next_check_cycle", 64'(got.next_check_cycle),
                          64'(want.next_check_cycle));
      end
    end
  end

  // receiver stalls; a requested hold keeps ready low until its counter, loaded from HoldCycles, runs out
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      out_ready_i <= 1'b0;
      hold_taken  <= hold_taken + 1;
      hold_left   <= HoldCycles;
    end else begin
      if (rx_phase == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:   out_ready_i <= rx_phase[1];
      endcase
    end
  end

  task automatic send_item(op_e op, logic [TimeWidth-1:0] stamp);
    in_item_t ev;
    ev.operation = op;
    ev.now_cycle = stamp;
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_readings.push_back(meter_predict(ev));
    items_sent++;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_CLOCK_HZ:        m_clock_hz = val[FreqWidth-1:0];
      REG_SILENCE_TIMEOUT: m_timeout  = val;
      REG_CHECK_INTERVAL:  m_interval = val;
      default: ;
    endcase
  endtask

  // reset registers: check before any toggle, first toggle, zero gap, timeout edge
  task automatic test_power_on_defaults();
    send_item(OP_CHECK,  48'd1_000_000);
    send_item(OP_TOGGLE, 48'd100);
    send_item(OP_TOGGLE, 48'd100);
    send_item(OP_TOGGLE, 48'd1100);
    send_item(OP_CHECK,  48'd801_100);
    send_item(OP_CHECK,  48'd801_101);
    send_item(OP_TOGGLE, 48'd2100);
  endtask

  // register extremes, saturation, time wrap, zero clock, spare index
  task automatic test_corner_cases();
    logic [TimeWidth-1:0] t;
    drain_results();
    write_reg(REG_CLOCK_HZ, '1);
    write_reg(REG_SILENCE_TIMEOUT, '0);
    write_reg(REG_CHECK_INTERVAL, '1);
    write_reg(RegSpare, 48'h0000_1234_5678);
    send_item(OP_TOGGLE, 48'hFFFF_FFFF_FFFE);
    send_item(OP_TOGGLE, 48'hFFFF_FFFF_FFFF);
    send_item(OP_CHECK,  48'hFFFF_FFFF_FFFF);
    t = 48'd2;
    send_item(OP_TOGGLE, t);
    t = t + 48'h0000_FFFF_FFFF;
    send_item(OP_TOGGLE, t);
    t = t + 48'h0001_0000_0000;
    send_item(OP_TOGGLE, t);
    t = t + 1'b1;
    send_item(OP_TOGGLE, t);
    send_item(OP_CHECK, t + 1'b1);
    drain_results();
    write_reg(REG_CLOCK_HZ, '0);
    write_reg(REG_SILENCE_TIMEOUT, '1);
    write_reg(REG_CHECK_INTERVAL, 48'd1);
    t = t + 48'd10;
    send_item(OP_TOGGLE, t);
    send_item(OP_CHECK, t - 1'b1);
    t = t + 48'd3;
    send_item(OP_TOGGLE, t);
  endtask

  // receiver holds off while the sender streams without gaps
  task automatic test_backpressure();
    logic [TimeWidth-1:0] t;
    drain_results();
    write_reg(REG_CLOCK_HZ, 48'd16_000_000);
    write_reg(REG_SILENCE_TIMEOUT, 48'd800_000);
    t = 48'h0000_5000_0000;
    bursty = 1'b0;
    hold_asked <= hold_asked + 1;
    repeat (12) begin
      t = t + 48'd700;
      send_item(OP_TOGGLE, t);
      send_item(OP_CHECK, t + 48'd100);
    end
    bursty = 1'b1;
  endtask

  // random tone bursts, silences, long gaps and noise under changing registers
  task automatic test_random_tones();
    logic [FreqWidth-1:0] clk;
    logic [TimeWidth-1:0] tmo;
    logic [TimeWidth-1:0] ivl;
    logic [TimeWidth-1:0] t;
    int unsigned          period;
    int unsigned          phase_start;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case ($urandom_range(0, 4))
        0:       clk = 32'd16_000_000;
        1:       clk = $urandom();
        2:       clk = $urandom_range(1, 1000);
        3:       clk = '1;
        default: clk = '0;
      endcase
      case ($urandom_range(0, 3))
        0:       tmo = TimeWidth'(clk / 20);
        1:       tmo = TimeWidth'($urandom_range(0, 20000));
        2:       tmo = TimeWidth'({$urandom(), $urandom()});
        default: tmo = '1;
      endcase
      case ($urandom_range(0, 2))
        0:       ivl = TimeWidth'(clk / 50);
        1:       ivl = TimeWidth'($urandom_range(1, 100000));
        default: ivl = TimeWidth'({$urandom(), $urandom()});
      endcase
      write_reg(REG_CLOCK_HZ, CfgWidth'(clk));
      write_reg(REG_SILENCE_TIMEOUT, tmo);
      write_reg(REG_CHECK_INTERVAL, ivl);
      if ($urandom_range(0, 1)) t = TimeWidth'({$urandom(), $urandom()});
      else t = '1 - TimeWidth'($urandom_range(0, 50000));
      phase_start = items_sent;
      while (items_sent - phase_start < 85) begin
        case ($urandom_range(0, 9))
          0: send_item(op_e'($urandom_range(0, 1)), TimeWidth'({$urandom(), $urandom()}));
          1: begin
            t = t + 48'h0000_FFFF_FFFF + $urandom_range(0, 2) - 1;
            send_item(OP_TOGGLE, t);
          end
          default: begin
            period = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20)
                                               : $urandom_range(1, 4000);
            repeat ($urandom_range(2, 10)) begin
              if ($urandom_range(0, 19) != 0) t = t + period + $urandom_range(0, 2);
              send_item(OP_TOGGLE, t);
              if ($urandom_range(0, 3) == 0)
                send_item(OP_CHECK, t + $urandom_range(0, period));
            end
            if ($urandom_range(0, 1)) begin
              send_item(OP_CHECK, t + m_timeout + $urandom_range(0, 1));
              t = t + m_timeout + $urandom_range(0, 100000);
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_on_defaults();
    test_corner_cases();
    test_backpressure();
    test_random_tones();
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpfm_pkg.sv
hw/rtl/tpfm_cfg.sv
hw/rtl/tpfm_div.sv
hw/rtl/tone_period_frequency_meter_unit.sv
hw/rtl/tpfm_checker.sv
verif/tb.sv
